FILE: src/sidta_pkg.sv
package sidta_pkg;

  localparam int unsigned DIGIT_W = 4;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [3:0] DABBLE_MIN = 4'd5;
  localparam logic [3:0] DABBLE_ADD = 4'd3;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  typedef struct packed {
    logic clr;
    logic dab;
    logic sh;
    logic bit_in;
  } bcd_ctl_t;

endpackage

FILE: src/sidta_dabble.sv
module sidta_dabble import sidta_pkg::*; #(
  parameter int unsigned NDIG = 10
) (
  input  logic                 clk,
  input  bcd_ctl_t             ctl,
  output logic [DIGIT_W-1:0]   top_digit
);

  localparam int unsigned BW = NDIG * DIGIT_W;

  logic [BW-1:0] bcd_r;
  logic [BW-1:0] bcd_nxt;
  logic [BW-1:0] adj;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
        adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end else begin
        adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    priority if (ctl.clr) begin
      bcd_nxt = '0;
    end else if (ctl.dab) begin
      bcd_nxt = {adj[BW-2:0], ctl.bit_in};
    end else if (ctl.sh) begin
      bcd_nxt = {bcd_r[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end else begin
      bcd_nxt = bcd_r;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BW-1 -: DIGIT_W];

endmodule

FILE: src/signed_int_to_decimal_ascii_top.sv
// channel  ports                          direction  accepted on
// in       in_valid in_ready in_value     input      in_valid & in_ready
// out      out_valid out_ready            output     out_valid & out_ready
//          out_character out_last
//
// load the magnitude, shift-and-add-3 over its VALUE_BITS bits, shift out the leading
// zero digits silently (at least one digit is kept), then emit a minus sign for a negative
// value followed by the digits, the last one marked with out_last
// a character is held in the output register until taken; a stalled output
// only holds the emit phase, and the next item loads while the last one waits
// rst_n is synchronous, active low, and empties the block and the output
module signed_int_to_decimal_ascii_top import sidta_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_character,
  output logic                         out_last
);

  localparam int unsigned NDIG = (VALUE_BITS * 3 + 9) / 10;
  localparam int unsigned BCW  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DCW  = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t                state_r,   state_nxt;
  logic [VALUE_BITS-1:0] mag_r,     mag_nxt;
  logic                  neg_r,     neg_nxt;
  logic [BCW-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]        dig_cnt_r, dig_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r,  out_char_nxt;
  logic                  out_last_r,  out_last_nxt;

  logic [VALUE_BITS-1:0] in_bits;
  logic [DIGIT_W-1:0]    top_digit;
  logic                  slot_free;
  bcd_ctl_t              ctl;

  assign in_bits   = in_value;
  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    ctl.bit_in    = mag_r[VALUE_BITS-1];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt     = in_bits[VALUE_BITS-1];
          mag_nxt     = in_bits[VALUE_BITS-1] ? (VALUE_BITS'(0) - in_bits) : in_bits;
          bit_cnt_nxt = BCW'(VALUE_BITS);
          ctl.clr     = 1'b1;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        ctl.dab     = 1'b1;
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BCW'(1);
        if (bit_cnt_r == BCW'(1)) begin
          dig_cnt_nxt = DCW'(NDIG);
          state_nxt   = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((top_digit == '0) && (dig_cnt_r > DCW'(1))) begin
          ctl.sh      = 1'b1;
          dig_cnt_nxt = dig_cnt_r - DCW'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = CHAR_ZERO + {4'b0000, top_digit};
            out_last_nxt = (dig_cnt_r == DCW'(1));
            ctl.sh       = 1'b1;
            dig_cnt_nxt  = dig_cnt_r - DCW'(1);
            if (dig_cnt_r == DCW'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
    end
    mag_r      <= mag_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  sidta_dabble #(
    .NDIG (NDIG)
  ) u_dabble (
    .clk       (clk),
    .ctl       (ctl),
    .top_digit (top_digit)
  );

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // only the final character of the previous item may still wait here
  a_conv_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) && out_valid_r |-> out_last_r)
    else $error("non-final character pending during conversion");

  a_load_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == S_CONV) && (bit_cnt_r == BCW'(VALUE_BITS)))
    else $error("conversion did not start after load");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SKIP) || (state_r == S_EMIT) |-> (dig_cnt_r != '0))
    else $error("digit count ran out");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS) ||
      ((out_char_r >= CHAR_ZERO) && (out_char_r <= (CHAR_ZERO + {4'b0000, DIGIT_MAX}))))
    else $error("bad character code");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked last");

endmodule
